FILE: hw/rtl/brm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brm_pkg
// Shared types and constants of the bivariate running moments core.
// ----------------------------------------------------------------------------
package brm_pkg;

  localparam int SAMPLE_W = 24;
  localparam int DELTA_W  = 25;
  localparam int PROD_W   = 50;
  localparam int VAR_W    = 48;
  localparam int COM_W    = 64;
  localparam int DIV_DW   = 64;
  localparam int DIV_CNT_W = 6;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MEAN_W,
    ST_VAR,
    ST_VAR_W,
    ST_SQ,
    ST_SQ_DIV,
    ST_SQ_W,
    ST_TERM,
    ST_TERM_ACC,
    ST_COV,
    ST_COV_W,
    ST_DONE
  } brm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } brm_div_stat_t;

endpackage
`default_nettype wire

FILE: hw/rtl/brm_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brm_div
// Restoring unsigned divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module brm_div
  import brm_pkg::*;
#(
  parameter int DIV_W = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DIV_DW-1:0]   dividend,
  input  wire logic [DIV_W-1:0]    divisor,
  output brm_div_stat_t            stat,
  output logic [DIV_DW-1:0]        quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_DW-1:0]    dvd_r, dvd_nxt;
  logic [DIV_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     dsr_r, dsr_nxt;
  logic [DIV_W:0]       rem_sh;
  logic [DIV_W:0]       rem_sub;
  logic                 ge;

  always_comb begin
    rem_sh  = {rem_r, dvd_r[DIV_DW-1]};
    rem_sub = rem_sh - {1'b0, dsr_r};
    ge      = rem_sh >= {1'b0, dsr_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (busy_r) begin
      // quotient bits shift in where dividend bits leave
      dvd_nxt = {dvd_r[DIV_DW-2:0], ge};
      rem_nxt = ge ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '1;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dvd_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

endmodule
`default_nettype wire

FILE: hw/rtl/brm_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// brm_mul
// Shared signed 25 x 25 multiplier with registered product.
// ----------------------------------------------------------------------------
module brm_mul
  import brm_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic signed [DELTA_W-1:0] op_a,
  input  wire logic signed [DELTA_W-1:0] op_b,
  output logic signed [PROD_W-1:0]       prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

FILE: hw/rtl/bivariate_running_moments_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bivariate_running_moments_core
// Welford running count, means, sample variances and covariance of pairs.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | in_sample_a, in_sample_b
// out     | output    | out_valid/out_ready  | count, means, variances, cov, flag
//
// one item takes up to seven divisions on the shared 1-bit-per-cycle divider,
// plus sequencer steps; only two divisions when count is 1
// in_ready is high only while the sequencer is idle
// a finished result waits in the output register; the next item may enter then
// synchronous active-low reset clears all statistics, no clearing pass
// ----------------------------------------------------------------------------
module bivariate_running_moments_core
  import brm_pkg::*;
#(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic signed [SAMPLE_W-1:0]  in_sample_a,
  input  wire logic signed [SAMPLE_W-1:0]  in_sample_b,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [15:0]                      out_sample_count,
  output logic signed [SAMPLE_W-1:0]       out_mean_a,
  output logic signed [SAMPLE_W-1:0]       out_mean_b,
  output logic [VAR_W-1:0]                 out_variance_a,
  output logic [VAR_W-1:0]                 out_variance_b,
  output logic signed [VAR_W-1:0]          out_covariance,
  output logic                             out_overflow_flag
);

  localparam logic signed [COM_W:0] COM_MAX = {2'b00, {(COM_W-1){1'b1}}};
  localparam logic signed [COM_W:0] COM_MIN = -COM_MAX;
  localparam logic [DIV_DW-1:0] COV_POS = {{(DIV_DW-VAR_W+1){1'b0}}, {(VAR_W-1){1'b1}}};
  localparam logic [DIV_DW-1:0] COV_NEG = COV_POS + 1'b1;

  brm_state_t state_r, state_nxt;
  logic sel_r, sel_nxt;
  logic signed [SAMPLE_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic signed [SAMPLE_W-1:0] mean_a_r, mean_a_nxt, mean_b_r, mean_b_nxt;
  logic [VAR_W-1:0] var_a_r, var_a_nxt, var_b_r, var_b_nxt;
  logic signed [COM_W-1:0] com_r, com_nxt;
  logic sat_r, sat_nxt;
  logic signed [DELTA_W-1:0] d_r, d_nxt;
  logic [VAR_W-1:0] v_r, v_nxt;
  logic signed [VAR_W-1:0] cov_r, cov_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [15:0] o_cnt_r, o_cnt_nxt;
  logic signed [SAMPLE_W-1:0] o_ma_r, o_ma_nxt, o_mb_r, o_mb_nxt;
  logic [VAR_W-1:0] o_va_r, o_va_nxt, o_vb_r, o_vb_nxt;
  logic signed [VAR_W-1:0] o_cov_r, o_cov_nxt;
  logic o_sat_r, o_sat_nxt;

  logic                  div_start;
  logic [DIV_DW-1:0]     div_dvd;
  logic [COUNT_BITS-1:0] div_dsr;
  brm_div_stat_t         div_stat;
  logic [DIV_DW-1:0]     div_q;
  logic signed [DELTA_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic signed [DELTA_W-1:0] d_cur;
  logic [DELTA_W-1:0]        d_mag;
  logic signed [SAMPLE_W-1:0] mean_sel;
  logic [VAR_W-1:0]          var_sel;
  logic signed [DELTA_W:0]   mean_upd;
  logic [VAR_W+1:0]          var_sum;
  logic signed [COM_W:0]     com_sum;
  logic [COM_W-1:0]          com_mag;
  logic [31:0]               cnt_ext;
  logic signed [VAR_W-1:0]   cov_val;
  logic                      cov_sat;
  logic                      n_gt1;

  brm_div #(.DIV_W(COUNT_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .stat     (div_stat),
    .quotient (div_q)
  );

  brm_mul u_mul (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  always_comb begin
    mean_sel = sel_r ? mean_b_r : mean_a_r;
    var_sel  = sel_r ? var_b_r : var_a_r;
    d_cur    = sel_r ? (DELTA_W'(b_r) - DELTA_W'(mean_b_r))
                     : (DELTA_W'(a_r) - DELTA_W'(mean_a_r));
    d_mag    = d_cur[DELTA_W-1] ? DELTA_W'(-d_cur) : DELTA_W'(d_cur);
    mean_upd = (DELTA_W+1)'(mean_sel) + (d_r[DELTA_W-1] ? -(DELTA_W+1)'(div_q[DELTA_W-1:0])
                                                         : (DELTA_W+1)'(div_q[DELTA_W-1:0]));
    var_sum  = (VAR_W+2)'(v_r) + (VAR_W+2)'(div_q[VAR_W:0]);
    com_sum  = (COM_W+1)'(com_r) + (COM_W+1)'(prod);
    com_mag  = com_r[COM_W-1] ? COM_W'(-com_r) : COM_W'(com_r);
    n_gt1    = count_r > COUNT_BITS'(1);
    cnt_ext  = 32'(count_r);
    cov_sat  = com_r[COM_W-1] ? (div_q > COV_NEG) : (div_q > COV_POS);
    if (com_r[COM_W-1]) begin
      cov_val = cov_sat ? {1'b1, {(VAR_W-1){1'b0}}} : VAR_W'(-div_q);
    end else begin
      cov_val = cov_sat ? {1'b0, {(VAR_W-1){1'b1}}} : VAR_W'(div_q);
    end

    state_nxt  = state_r;
    sel_nxt    = sel_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    count_nxt  = count_r;
    mean_a_nxt = mean_a_r;
    mean_b_nxt = mean_b_r;
    var_a_nxt  = var_a_r;
    var_b_nxt  = var_b_r;
    com_nxt    = com_r;
    sat_nxt    = sat_r;
    d_nxt      = d_r;
    v_nxt      = v_r;
    cov_nxt    = cov_r;
    out_valid_nxt = out_valid_r && !out_ready;
    o_cnt_nxt  = o_cnt_r;
    o_ma_nxt   = o_ma_r;
    o_mb_nxt   = o_mb_r;
    o_va_nxt   = o_va_r;
    o_vb_nxt   = o_vb_r;
    o_cov_nxt  = o_cov_r;
    o_sat_nxt  = o_sat_r;
    div_start  = 1'b0;
    div_dvd    = '0;
    div_dsr    = count_r;
    mul_a      = '0;
    mul_b      = '0;
    in_ready   = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          a_nxt   = in_sample_a;
          b_nxt   = in_sample_b;
          sel_nxt = 1'b0;
          if (count_r != '1) begin
            count_nxt = count_r + 1'b1;
          end else begin
            sat_nxt = 1'b1;
          end
          state_nxt = ST_MEAN;
        end
      end
      ST_MEAN: begin
        d_nxt     = d_cur;
        div_start = 1'b1;
        div_dvd   = DIV_DW'(d_mag);
        state_nxt = ST_MEAN_W;
      end
      ST_MEAN_W: begin
        if (div_stat.done) begin
          if (sel_r) mean_b_nxt = SAMPLE_W'(mean_upd);
          else       mean_a_nxt = SAMPLE_W'(mean_upd);
          if (n_gt1)      state_nxt = ST_VAR;
          else if (sel_r) state_nxt = ST_COV;
          else            state_nxt = ST_TERM;
        end
      end
      ST_VAR: begin
        div_start = 1'b1;
        div_dvd   = DIV_DW'(var_sel);
        div_dsr   = count_r - 1'b1;
        state_nxt = ST_VAR_W;
      end
      ST_VAR_W: begin
        if (div_stat.done) begin
          v_nxt     = var_sel - div_q[VAR_W-1:0];
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        mul_a     = d_r;
        mul_b     = d_r;
        state_nxt = ST_SQ_DIV;
      end
      ST_SQ_DIV: begin
        div_start = 1'b1;
        div_dvd   = DIV_DW'(unsigned'(prod));
        state_nxt = ST_SQ_W;
      end
      ST_SQ_W: begin
        if (div_stat.done) begin
          // variance clamps at the top of its 48-bit range
          if (var_sum[VAR_W+1:VAR_W] != 2'b00) begin
            sat_nxt = 1'b1;
            if (sel_r) var_b_nxt = '1;
            else       var_a_nxt = '1;
          end else begin
            if (sel_r) var_b_nxt = var_sum[VAR_W-1:0];
            else       var_a_nxt = var_sum[VAR_W-1:0];
          end
          state_nxt = sel_r ? ST_COV : ST_TERM;
        end
      end
      ST_TERM: begin
        // new mean of a against the old mean of b
        mul_a     = DELTA_W'(a_r) - DELTA_W'(mean_a_r);
        mul_b     = DELTA_W'(b_r) - DELTA_W'(mean_b_r);
        state_nxt = ST_TERM_ACC;
      end
      ST_TERM_ACC: begin
        if (com_sum > COM_MAX) begin
          com_nxt = COM_W'(COM_MAX);
          sat_nxt = 1'b1;
        end else if (com_sum < COM_MIN) begin
          com_nxt = COM_W'(COM_MIN);
          sat_nxt = 1'b1;
        end else begin
          com_nxt = COM_W'(com_sum);
        end
        sel_nxt   = 1'b1;
        state_nxt = ST_MEAN;
      end
      ST_COV: begin
        if (n_gt1) begin
          div_start = 1'b1;
          div_dvd   = com_mag;
          div_dsr   = count_r - 1'b1;
          state_nxt = ST_COV_W;
        end else begin
          cov_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_COV_W: begin
        if (div_stat.done) begin
          cov_nxt = cov_val;
          if (cov_sat) sat_nxt = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_cnt_nxt = (cnt_ext > 32'h0000FFFF) ? 16'hFFFF : cnt_ext[15:0];
          o_ma_nxt  = mean_a_r;
          o_mb_nxt  = mean_b_r;
          o_va_nxt  = var_a_r;
          o_vb_nxt  = var_b_r;
          o_cov_nxt = cov_r;
          o_sat_nxt = sat_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sel_r       <= 1'b0;
      count_r     <= '0;
      mean_a_r    <= '0;
      mean_b_r    <= '0;
      var_a_r     <= '0;
      var_b_r     <= '0;
      com_r       <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sel_r       <= sel_nxt;
      count_r     <= count_nxt;
      mean_a_r    <= mean_a_nxt;
      mean_b_r    <= mean_b_nxt;
      var_a_r     <= var_a_nxt;
      var_b_r     <= var_b_nxt;
      com_r       <= com_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    d_r     <= d_nxt;
    v_r     <= v_nxt;
    cov_r   <= cov_nxt;
    o_cnt_r <= o_cnt_nxt;
    o_ma_r  <= o_ma_nxt;
    o_mb_r  <= o_mb_nxt;
    o_va_r  <= o_va_nxt;
    o_vb_r  <= o_vb_nxt;
    o_cov_r <= o_cov_nxt;
    o_sat_r <= o_sat_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_sample_count  = o_cnt_r;
  assign out_mean_a        = o_ma_r;
  assign out_mean_b        = o_mb_r;
  assign out_variance_a    = o_va_r;
  assign out_variance_b    = o_vb_r;
  assign out_covariance    = o_cov_r;
  assign out_overflow_flag = o_sat_r;

  a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(sat_r) && $past(rst_n) |-> sat_r)
    else $error("saturation flag cleared without reset");

  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("division started while divider busy");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && count_r != '1 |=> count_r == $past(count_r) + 1'b1)
    else $error("count not advanced on accepted item");

  a_done_load: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && (!out_valid_r || out_ready) |=> out_valid_r)
    else $error("finished result not presented");

endmodule
`default_nettype wire
